// ===== src/bls_pkg.sv =====
// Shared constants and types for the Bresenham line stepper.
package bls_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    // Command selector carried on the input tuser.
    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_LINE = 2'd1,
        FUNC_HOME = 2'd2,
        FUNC_RSVD = 2'd3
    } t_func;

    // Per-beat status flags of one result.
    typedef struct packed {
        logic refused;
        logic finished;
        logic busy_res;
        logic y_backward;
        logic x_backward;
        logic y_step;
        logic x_step;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ===== src/bls_core.sv =====
// Motion state registers and the per-beat line / homing step logic.
module bls_core #(
    parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic [1:0]             i_func,
    input  logic [COORD_WIDTH-1:0] i_target_x,
    input  logic [COORD_WIDTH-1:0] i_target_y,
    input  logic                   i_limit_xmin,
    output bls_pkg::t_flags        o_flags,
    output logic [COORD_WIDTH-1:0] o_pos_x,
    output logic [COORD_WIDTH-1:0] o_pos_y
);
    import bls_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int E = COORD_WIDTH + 2;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_LINE = 2'd1,
        MODE_HOME = 2'd2
    } t_mode;

    t_mode              r_mode,      n_mode;
    logic [W-1:0]       r_pos_x,     n_pos_x;
    logic [W-1:0]       r_pos_y,     n_pos_y;
    logic [W-1:0]       r_steps,     n_steps;
    logic signed [E-1:0] r_err,      n_err;
    logic signed [E-1:0] r_minor2,   n_minor2;
    logic signed [E-1:0] r_both,     n_both;
    logic               r_x_major,   n_x_major;
    logic               r_dir_x,     n_dir_x;
    logic               r_dir_y,     n_dir_y;

    logic               x_back, y_back, x_major, minor, is_cmd;
    logic [W-1:0]       dx, dy, dmaj, dmin, steps_dec;
    logic signed [E-1:0] min2, maj2, maj1;
    t_flags             flags;

    // Line setup terms, evaluated in parallel from the held position.
    always_comb begin
        x_back  = $signed(r_pos_x) > $signed(i_target_x);
        y_back  = $signed(r_pos_y) > $signed(i_target_y);
        dx      = x_back ? r_pos_x - i_target_x : i_target_x - r_pos_x;
        dy      = y_back ? r_pos_y - i_target_y : i_target_y - r_pos_y;
        x_major = dx >= dy;
        dmaj    = x_major ? dx : dy;
        dmin    = x_major ? dy : dx;
        min2    = {1'b0, dmin, 1'b0};
        maj2    = {1'b0, dmaj, 1'b0};
        maj1    = {2'b00, dmaj};
    end

    always_comb begin
        n_mode    = r_mode;
        n_pos_x   = r_pos_x;
        n_pos_y   = r_pos_y;
        n_steps   = r_steps;
        n_err     = r_err;
        n_minor2  = r_minor2;
        n_both    = r_both;
        n_x_major = r_x_major;
        n_dir_x   = r_dir_x;
        n_dir_y   = r_dir_y;
        flags     = '0;
        minor     = 1'b0;
        steps_dec = (r_steps != '0) ? r_steps - 1'b1 : '0;
        is_cmd    = (i_func == FUNC_LINE) || (i_func == FUNC_HOME);

        if (is_cmd && r_mode != MODE_IDLE) begin
            flags.refused = 1'b1;
        end else if (i_func == FUNC_LINE) begin
            n_dir_x   = x_back;
            n_dir_y   = y_back;
            n_x_major = x_major;
            n_minor2  = min2;
            n_both    = min2 - maj2;
            n_err     = min2 - maj1;
            n_steps   = dmaj;
            if (dmaj == '0) begin
                n_mode         = MODE_IDLE;
                flags.finished = 1'b1;
            end else begin
                n_mode = MODE_LINE;
            end
        end else if (i_func == FUNC_HOME) begin
            n_dir_x = 1'b1;
            if (i_limit_xmin) begin
                n_pos_x        = '0;
                n_pos_y        = '0;
                n_mode         = MODE_IDLE;
                flags.finished = 1'b1;
            end else begin
                n_mode = MODE_HOME;
            end
        end else begin
            case (r_mode)
                MODE_LINE: begin
                    minor        = r_err > 0;
                    n_err        = r_err + (minor ? r_both : r_minor2);
                    flags.x_step = r_x_major || minor;
                    flags.y_step = !r_x_major || minor;
                    if (flags.x_step) begin
                        n_pos_x = r_dir_x ? r_pos_x - 1'b1 : r_pos_x + 1'b1;
                    end
                    if (flags.y_step) begin
                        n_pos_y = r_dir_y ? r_pos_y - 1'b1 : r_pos_y + 1'b1;
                    end
                    n_steps = steps_dec;
                    if (steps_dec == '0) begin
                        n_mode         = MODE_IDLE;
                        flags.finished = 1'b1;
                    end
                end
                MODE_HOME: begin
                    if (i_limit_xmin) begin
                        n_pos_x        = '0;
                        n_pos_y        = '0;
                        n_mode         = MODE_IDLE;
                        flags.finished = 1'b1;
                    end else begin
                        flags.x_step = 1'b1;
                        n_pos_x      = r_pos_x - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        flags.x_backward = n_dir_x;
        flags.y_backward = n_dir_y;
        flags.busy_res   = n_mode != MODE_IDLE;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_IDLE;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_steps   <= '0;
            r_err     <= '0;
            r_minor2  <= '0;
            r_both    <= '0;
            r_x_major <= 1'b1;
            r_dir_x   <= 1'b0;
            r_dir_y   <= 1'b0;
        end else if (i_en) begin
            r_mode    <= n_mode;
            r_pos_x   <= n_pos_x;
            r_pos_y   <= n_pos_y;
            r_steps   <= n_steps;
            r_err     <= n_err;
            r_minor2  <= n_minor2;
            r_both    <= n_both;
            r_x_major <= n_x_major;
            r_dir_x   <= n_dir_x;
            r_dir_y   <= n_dir_y;
        end
    end

    assign o_flags = flags;
    assign o_pos_x = n_pos_x;
    assign o_pos_y = n_pos_y;

endmodule

// ===== src/bresenham_line_stepper.sv =====
// Two-axis Bresenham line stepper: input register, step core, result register.
//
// Usage:
//   Slave stream carries one command beat: tuser selects tick, start line or
//   start homing; tdata holds the target point and the X minimum limit bit.
//   Each accepted beat yields exactly one master beat with the step pulses,
//   direction levels, busy / finished / refused flags and the new position.
//   A line command only loads the Bresenham terms; each following tick gives
//   one major-axis step plus a minor step when the error term is positive.
//   Homing steps X backward per tick until the limit bit reads 1, then zeroes
//   both positions. Commands arriving during a move are refused.
// Timing:
//   A beat passes through the input register, then the step core into the result
//   register. Throughput is one beat per cycle while the master side does not stall;
//   the position and error registers are updated by a single add / compare per beat.
// Reset and stall:
//   Synchronous active-low reset clears both pipeline stages, parks the
//   position at the origin and leaves the stepper idle. While the master side
//   stalls, results hold and the input register still takes one more beat.
module bresenham_line_stepper #(
    parameter int COORD_WIDTH = bls_pkg::COORD_WIDTH_DEF,
    localparam int InTdataW   = ((2 * COORD_WIDTH + 1 + 7) / 8) * 8,
    localparam int OutTdataW  = ((2 * COORD_WIDTH + bls_pkg::FLAGS_W + 7) / 8) * 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // tdata: target_x, target_y, limit_xmin, zero pad
    input  logic [InTdataW-1:0]  i_s_axis_tdata,
    // tuser: func
    input  logic [1:0]           i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // tdata: x_step, y_step, x_backward, y_backward, busy_res, finished,
    //        refused, pos_x, pos_y, zero pad
    output logic [OutTdataW-1:0] o_m_axis_tdata
);
    import bls_pkg::*;

    localparam int W     = COORD_WIDTH;
    localparam int OUT_W = 2 * W + FLAGS_W;

    logic         r_in_valid;
    logic [1:0]   r_in_func;
    logic [W-1:0] r_in_tx, r_in_ty;
    logic         r_in_lim;

    logic         r_out_valid;
    t_flags       r_out_flags;
    logic [W-1:0] r_out_px, r_out_py;

    logic         out_ok, adv, s_acc;
    t_flags       core_flags;
    logic [W-1:0] core_px, core_py;

    assign out_ok          = !r_out_valid || i_m_axis_tready;
    assign adv             = r_in_valid && out_ok;
    assign o_s_axis_tready = !r_in_valid || out_ok;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_func <= i_s_axis_tuser;
            r_in_tx   <= i_s_axis_tdata[W-1:0];
            r_in_ty   <= i_s_axis_tdata[2*W-1:W];
            r_in_lim  <= i_s_axis_tdata[2*W];
        end
    end

    bls_core #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (adv),
        .i_func      (r_in_func),
        .i_target_x  (r_in_tx),
        .i_target_y  (r_in_ty),
        .i_limit_xmin(r_in_lim),
        .o_flags     (core_flags),
        .o_pos_x     (core_px),
        .o_pos_y     (core_py)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_flags <= core_flags;
            r_out_px    <= core_px;
            r_out_py    <= core_py;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OutTdataW - OUT_W){1'b0}}, r_out_py, r_out_px, r_out_flags};

endmodule
